// ===== rtl/button_edge_event_latch_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button edge event latch
// Clocked on clk; the first form is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_EDGE_EVENT_LATCH_ASSERT_SVH
`define BUTTON_EDGE_EVENT_LATCH_ASSERT_SVH

// check outside reset
`define BEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds while reset is applied
`define BEL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bel_pkg.sv =====
// ----------------------------------------------------------------------------
// bel_pkg
// Word types, item kinds and helpers for the button edge event latch.
// ----------------------------------------------------------------------------
package bel_pkg;

  localparam int MASK_W     = 7;   // buttons carried in the output masks
  localparam int GROUP_SIZE = 4;   // buttons reduced together in the first stage
  localparam int MAX_GROUPS = 4;   // enough groups for the largest bank

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] button_index;
    logic       key_down;
  } in_word_t;

  typedef struct packed {
    logic [MASK_W-1:0] held_mask;
    logic [MASK_W-1:0] frame_press_mask;
    logic [MASK_W-1:0] frame_release_mask;
    logic              any_pressed;
    logic              any_released;
  } flags_t;

  typedef struct packed {
    logic [MASK_W-1:0] held_mask;
    logic [MASK_W-1:0] frame_press_mask;
    logic [MASK_W-1:0] frame_release_mask;
    logic              any_pressed;
    logic              any_released;
    logic [31:0]       longest_held_ms;
  } out_word_t;

  typedef struct packed {
    logic load;    // stage takes new contents this cycle
    logic valid;   // contents offered from upstream are live
  } stage_ctl_t;

  function automatic logic [31:0] max32(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/bel_state.sv =====
// ----------------------------------------------------------------------------
// bel_state
// Button levels, pending and frame marks, press stamps and the ms counter.
// ----------------------------------------------------------------------------
module bel_state
  import bel_pkg::*;
#(
  parameter int BUTTONS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  in_word_t           in_word,
  output logic [BUTTONS-1:0] held,
  output logic [BUTTONS-1:0] frame_press,
  output logic [BUTTONS-1:0] frame_release,
  output logic [31:0]        press_stamp [BUTTONS],
  output logic [31:0]        now_ms
);

  logic [BUTTONS-1:0] held_r, held_nxt;
  logic [BUTTONS-1:0] pend_press_r, pend_press_nxt;
  logic [BUTTONS-1:0] pend_rel_r, pend_rel_nxt;
  logic [BUTTONS-1:0] frame_press_r, frame_press_nxt;
  logic [BUTTONS-1:0] frame_rel_r, frame_rel_nxt;
  logic [31:0]        stamp_r [BUTTONS];
  logic [31:0]        stamp_nxt [BUTTONS];
  logic [31:0]        now_r, now_nxt;

  always_comb begin
    held_nxt        = held_r;
    pend_press_nxt  = pend_press_r;
    pend_rel_nxt    = pend_rel_r;
    frame_press_nxt = frame_press_r;
    frame_rel_nxt   = frame_rel_r;
    stamp_nxt       = stamp_r;
    now_nxt         = now_r;
    if (accept) begin
      case (in_word.kind)
        KIND_KEY: begin
          // out-of-bank indices match no button
          for (int b = 0; b < BUTTONS; b++) begin
            if (in_word.button_index == 4'(b)) begin
              if (in_word.key_down && !held_r[b]) begin
                held_nxt[b]       = 1'b1;
                pend_press_nxt[b] = 1'b1;
                stamp_nxt[b]      = now_r;
              end else if (!in_word.key_down && held_r[b]) begin
                held_nxt[b]     = 1'b0;
                pend_rel_nxt[b] = 1'b1;
              end
            end
          end
        end
        KIND_FRAME: begin
          frame_press_nxt = pend_press_r;
          frame_rel_nxt   = pend_rel_r;
          pend_press_nxt  = '0;
          pend_rel_nxt    = '0;
        end
        KIND_TICK: begin
          now_nxt = now_r + 32'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r        <= '0;
      pend_press_r  <= '0;
      pend_rel_r    <= '0;
      frame_press_r <= '0;
      frame_rel_r   <= '0;
      now_r         <= '0;
      for (int b = 0; b < BUTTONS; b++) begin
        stamp_r[b] <= '0;
      end
    end else begin
      held_r        <= held_nxt;
      pend_press_r  <= pend_press_nxt;
      pend_rel_r    <= pend_rel_nxt;
      frame_press_r <= frame_press_nxt;
      frame_rel_r   <= frame_rel_nxt;
      now_r         <= now_nxt;
      stamp_r       <= stamp_nxt;
    end
  end

  assign held          = held_r;
  assign frame_press   = frame_press_r;
  assign frame_release = frame_rel_r;
  assign press_stamp   = stamp_r;
  assign now_ms        = now_r;

endmodule

// ===== rtl/bel_span.sv =====
// ----------------------------------------------------------------------------
// bel_span
// Masks and per-group longest held time, taken from the updated state.
// ----------------------------------------------------------------------------
module bel_span
  import bel_pkg::*;
#(
  parameter int BUTTONS = 7,
  parameter int GROUPS  = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stage_ctl_t         ctl,
  input  logic [BUTTONS-1:0] held,
  input  logic [BUTTONS-1:0] frame_press,
  input  logic [BUTTONS-1:0] frame_release,
  input  logic [31:0]        press_stamp [BUTTONS],
  input  logic [31:0]        now_ms,
  output logic               valid,
  output flags_t             flags,
  output logic [31:0]        grp_max [GROUPS]
);

  localparam int PAD = GROUPS * GROUP_SIZE;
  localparam int MW  = (BUTTONS < MASK_W) ? BUTTONS : MASK_W;   // buttons shown in masks

  logic [31:0] elapsed [PAD];
  logic [31:0] grp_nxt [GROUPS];
  flags_t      flags_nxt;
  logic        valid_r;
  flags_t      flags_r;
  logic [31:0] grp_r [GROUPS];

  always_comb begin
    for (int b = 0; b < PAD; b++) begin
      elapsed[b] = '0;
    end
    // a stamp of zero leaves the button out
    for (int b = 0; b < BUTTONS; b++) begin
      if (held[b] && (press_stamp[b] != '0)) begin
        elapsed[b] = now_ms - press_stamp[b];
      end
    end
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = max32(max32(elapsed[g*GROUP_SIZE],     elapsed[g*GROUP_SIZE + 1]),
                         max32(elapsed[g*GROUP_SIZE + 2], elapsed[g*GROUP_SIZE + 3]));
    end
  end

  always_comb begin
    flags_nxt = '0;
    flags_nxt.held_mask[MW-1:0]          = held[MW-1:0];
    flags_nxt.frame_press_mask[MW-1:0]   = frame_press[MW-1:0];
    flags_nxt.frame_release_mask[MW-1:0] = frame_release[MW-1:0];
    flags_nxt.any_pressed  = |frame_press;
    flags_nxt.any_released = |frame_release;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      flags_r <= flags_nxt;
      grp_r   <= grp_nxt;
    end
  end

  assign valid   = valid_r;
  assign flags   = flags_r;
  assign grp_max = grp_r;

endmodule

// ===== rtl/bel_result.sv =====
// ----------------------------------------------------------------------------
// bel_result
// Final max over the groups and the output word register.
// ----------------------------------------------------------------------------
module bel_result
  import bel_pkg::*;
#(
  parameter int GROUPS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  stage_ctl_t  ctl,
  input  flags_t      flags,
  input  logic [31:0] grp_max [GROUPS],
  output logic        out_valid,
  output out_word_t   out_word
);

  logic [31:0] grp_pad [MAX_GROUPS];
  logic [31:0] longest;
  logic        valid_r;
  out_word_t   word_r;

  for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_pad
    if (g < GROUPS) begin : g_live
      assign grp_pad[g] = grp_max[g];
    end else begin : g_zero
      assign grp_pad[g] = '0;
    end
  end

  assign longest = max32(max32(grp_pad[0], grp_pad[1]), max32(grp_pad[2], grp_pad[3]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word_r.held_mask          <= flags.held_mask;
      word_r.frame_press_mask   <= flags.frame_press_mask;
      word_r.frame_release_mask <= flags.frame_release_mask;
      word_r.any_pressed        <= flags.any_pressed;
      word_r.any_released       <= flags.any_released;
      word_r.longest_held_ms    <= longest;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== rtl/button_edge_event_latch.sv =====
// ----------------------------------------------------------------------------
// button_edge_event_latch
// Button bank with frame-latched press and release marks and held time.
//
// Input words carry a key event, a frame update or a 1 ms tick; every
// accepted word yields exactly one output word, in order. A word is taken
// on a rising edge with valid high and stall low, on both channels.
// The state is updated at the edge that accepts the word. The output word
// is built from that updated state in two register stages: masks and a
// per-group max of elapsed times (groups of four buttons), then the max
// over groups. Throughput is one word per cycle while the receiver
// does not stall; the limit is the four-way 32-bit max between the
// stage registers.
// When the receiver stalls, the output word holds and the stages fill;
// input stall rises only once no stage below the state can take a word.
// Synchronous reset clears levels, marks, stamps, the ms counter and all
// stage valid flags; the block accepts words in the cycle after reset.
// ----------------------------------------------------------------------------
module button_edge_event_latch
  import bel_pkg::*;
#(
  parameter int BUTTONS = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int GROUPS = (BUTTONS + GROUP_SIZE - 1) / GROUP_SIZE;

  logic               accept;
  logic               fresh_r;   // state holds a word not yet summarised
  logic               span_valid;
  logic               out_move;
  logic               span_move;
  stage_ctl_t         span_ctl;
  stage_ctl_t         res_ctl;
  logic [BUTTONS-1:0] held;
  logic [BUTTONS-1:0] frame_press;
  logic [BUTTONS-1:0] frame_release;
  logic [31:0]        press_stamp [BUTTONS];
  logic [31:0]        now_ms;
  flags_t             flags;
  logic [31:0]        grp_max [GROUPS];

  assign out_move  = !out_valid || !out_stall;
  assign span_move = !span_valid || out_move;
  assign in_stall  = fresh_r && !span_move;
  assign accept    = in_valid && !in_stall;

  assign span_ctl = '{load: span_move, valid: fresh_r};
  assign res_ctl  = '{load: out_move,  valid: span_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b0;
    end else if (!fresh_r || span_move) begin
      fresh_r <= accept;
    end
  end

  bel_state #(.BUTTONS(BUTTONS)) u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_word       (in_word),
    .held          (held),
    .frame_press   (frame_press),
    .frame_release (frame_release),
    .press_stamp   (press_stamp),
    .now_ms        (now_ms)
  );

  bel_span #(.BUTTONS(BUTTONS), .GROUPS(GROUPS)) u_span (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (span_ctl),
    .held          (held),
    .frame_press   (frame_press),
    .frame_release (frame_release),
    .press_stamp   (press_stamp),
    .now_ms        (now_ms),
    .valid         (span_valid),
    .flags         (flags),
    .grp_max       (grp_max)
  );

  bel_result #(.GROUPS(GROUPS)) u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (res_ctl),
    .flags     (flags),
    .grp_max   (grp_max),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ===== rtl/bel_checker.sv =====
// ----------------------------------------------------------------------------
// bel_checker
// Port-level checks on the button edge event latch, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_edge_event_latch_assert.svh"

module bel_checker
  import bel_pkg::*;
#(
  parameter int BUTTONS = 7
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  logic flags_ok;

  // with a bank of seven or fewer the OR flags follow the masks exactly
  assign flags_ok = (BUTTONS > MASK_W) ||
                    ((out_word.any_pressed == (|out_word.frame_press_mask)) &&
                     (out_word.any_released == (|out_word.frame_release_mask)));

  `BEL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output word dropped under stall")
  `BEL_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_word), "stalled word changed")
  `BEL_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "output valid after reset")
  `BEL_ASSERT(a_any_flags, out_valid |-> flags_ok, "OR flags disagree with masks")
  `BEL_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_word), "input word moved")

endmodule

bind button_edge_event_latch bel_checker #(.BUTTONS(BUTTONS)) u_bel_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for button_edge_event_latch
// Key, frame and tick words are queued up front and fed through a driver
// with random gaps. A local model of the button bank predicts one output
// word per accepted input word. The monitor stalls at random and checks
// every output word against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import bel_pkg::*;

  localparam int          NUM_BUTTONS  = 7;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int          RAND_WORDS   = 1930;
  localparam int          CALM_FROM    = 800;   // no idling on either side in this window
  localparam int          CALM_TO      = 1600;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          TAIL_CYCLES  = 12;

  typedef struct packed {
    in_word_t word;
    logic     drain;   // hold off until every prediction has been matched
  } stim_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;

  stim_item_t stim_q[$];
  out_word_t  expected_q[$];
  int         mismatches = 0;
  int         cyc = 0;
  int         quiet_cyc = 0;

  // model of the bank
  logic [NUM_BUTTONS-1:0] held_lvl = '0;
  logic [NUM_BUTTONS-1:0] pend_press = '0;
  logic [NUM_BUTTONS-1:0] pend_release = '0;
  logic [NUM_BUTTONS-1:0] frm_press = '0;
  logic [NUM_BUTTONS-1:0] frm_release = '0;
  logic [31:0]            stamp [NUM_BUTTONS];
  logic [31:0]            now_ms = '0;

  button_edge_event_latch #(
    .BUTTONS(NUM_BUTTONS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // advances the bank model by one word and returns the word it should report
  function automatic out_word_t apply_button_word(in_word_t w);
    out_word_t   r;
    logic [31:0] el;
    logic [2:0]  bi;
    r  = '0;
    bi = w.button_index[2:0];
    case (w.kind)
      KIND_KEY: begin
        if (w.button_index < NUM_BUTTONS) begin
          if (w.key_down && !held_lvl[bi]) begin
            held_lvl[bi]   = 1'b1;
            pend_press[bi] = 1'b1;
            stamp[bi]      = now_ms;
          end else if (!w.key_down && held_lvl[bi]) begin
            held_lvl[bi]     = 1'b0;
            pend_release[bi] = 1'b1;
          end
        end
      end
      KIND_FRAME: begin
        frm_press    = pend_press;
        frm_release  = pend_release;
        pend_press   = '0;
        pend_release = '0;
      end
      KIND_TICK: now_ms = now_ms + 32'd1;
      default: ;
    endcase
    r.held_mask          = held_lvl;
    r.frame_press_mask   = frm_press;
    r.frame_release_mask = frm_release;
    r.any_pressed        = |frm_press;
    r.any_released       = |frm_release;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      // a stamp of zero means pressed before the first tick: not timed
      if (held_lvl[b] && stamp[b] != 32'd0) begin
        el = now_ms - stamp[b];
        if (el > r.longest_held_ms) r.longest_held_ms = el;
      end
    end
    return r;
  endfunction

  function automatic logic take_break();
    if (cyc >= CALM_FROM && cyc < CALM_TO) return 1'b0;
    return $urandom_range(99) < 14;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_word(logic [1:0] kind, logic [3:0] idx, logic down, logic drain);
    stim_item_t s;
    s.word.kind         = kind;
    s.word.button_index = idx;
    s.word.key_down     = down;
    s.drain             = drain;
    stim_q.push_back(s);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(apply_button_word(in_word));
      if (!(in_valid && in_stall)) begin
        if (stim_q.size() != 0 && !(stim_q[0].drain && expected_q.size() != 0)
            && !take_break()) begin
          in_valid <= 1'b1;
          in_word  <= stim_q.pop_front().word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("output word with nothing expected");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("held_mask", 32'(want.held_mask), 32'(out_word.held_mask));
          check_field("frame_press_mask", 32'(want.frame_press_mask),
                      32'(out_word.frame_press_mask));
          check_field("frame_release_mask", 32'(want.frame_release_mask),
                      32'(out_word.frame_release_mask));
          check_field("any_pressed", 32'(want.any_pressed), 32'(out_word.any_pressed));
          check_field("any_released", 32'(want.any_released), 32'(out_word.any_released));
          check_field("longest_held_ms", want.longest_held_ms, out_word.longest_held_ms);
        end
      end
      out_stall <= take_break();
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  initial begin
    int r;
    for (int b = 0; b < NUM_BUTTONS; b++) stamp[b] = '0;

    // directed: presses before the first tick, repeats, out of bank, unused kind
    queue_word(KIND_KEY, 4'd0, 1'b1, 1'b0);   // stamped at zero, never timed
    queue_word(KIND_FRAME, 4'd0, 1'b0, 1'b0);
    queue_word(KIND_TICK, 4'd0, 1'b0, 1'b0);
    queue_word(KIND_KEY, 4'd6, 1'b1, 1'b0);
    queue_word(KIND_KEY, 4'd6, 1'b1, 1'b0);   // repeated down
    queue_word(KIND_KEY, 4'd3, 1'b0, 1'b0);   // up on a button not held
    queue_word(KIND_KEY, 4'd7, 1'b1, 1'b0);   // first index past the bank
    queue_word(KIND_KEY, 4'd15, 1'b1, 1'b0);
    queue_word(KIND_KEY, 4'd15, 1'b0, 1'b0);
    queue_word(KIND_UNUSED, 4'd15, 1'b1, 1'b0);
    queue_word(KIND_TICK, 4'd15, 1'b1, 1'b0);
    queue_word(KIND_FRAME, 4'd9, 1'b1, 1'b0);
    queue_word(KIND_TICK, 4'd0, 1'b0, 1'b0);
    queue_word(KIND_TICK, 4'd0, 1'b0, 1'b0);
    queue_word(KIND_KEY, 4'd1, 1'b1, 1'b0);
    queue_word(KIND_KEY, 4'd0, 1'b0, 1'b0);
    queue_word(KIND_KEY, 4'd6, 1'b0, 1'b0);
    queue_word(KIND_TICK, 4'd0, 1'b0, 1'b0);
    queue_word(KIND_FRAME, 4'd0, 1'b0, 1'b0);
    queue_word(KIND_FRAME, 4'd0, 1'b0, 1'b0); // clears the frame marks
    queue_word(KIND_UNUSED, 4'd0, 1'b0, 1'b0);
    queue_word(KIND_KEY, 4'd5, 1'b1, 1'b0);
    queue_word(KIND_TICK, 4'd0, 1'b0, 1'b0);

    // random: mostly in-bank keys and ticks so stamps and held times move
    for (int n = 0; n < RAND_WORDS; n++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        queue_word(KIND_KEY,
                   ($urandom_range(99) < 90) ? 4'($urandom_range(NUM_BUTTONS - 1))
                                             : 4'($urandom_range(15, NUM_BUTTONS)),
                   1'($urandom_range(1)), n == 0 || n == RAND_WORDS / 2);
      end else if (r < 60) begin
        queue_word(KIND_FRAME, 4'($urandom_range(15)), 1'($urandom_range(1)),
                   n == 0 || n == RAND_WORDS / 2);
      end else if (r < 96) begin
        queue_word(KIND_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)),
                   n == 0 || n == RAND_WORDS / 2);
      end else begin
        queue_word(KIND_UNUSED, 4'($urandom_range(15)), 1'($urandom_range(1)),
                   n == 0 || n == RAND_WORDS / 2);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bel_pkg.sv
rtl/bel_state.sv
rtl/bel_span.sv
rtl/bel_result.sv
rtl/button_edge_event_latch.sv
rtl/bel_checker.sv
tb/sv/tb_top.sv
